### src/cdc_pkg.sv
// Package for the calendar date counter: field widths, codes, the
// controller-to-datapath command and status structs, and calendar tables.
// No dependencies.
package cdc_pkg;

    // Field widths
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 14;
    localparam int WDAY_W    = 3;
    localparam int ORD_W     = 9;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    // Calendar limits and reset date
    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [DAY_W-1:0]   RST_DAY    = 5'd1;
    localparam logic [MONTH_W-1:0] RST_MONTH  = 4'd1;
    localparam logic [YEAR_W-1:0]  RST_YEAR   = 14'd2000;

    // Reciprocal constants: x / 100 for x < 16384, x / 7 for x < 1024
    localparam int PROD_W     = 27;
    localparam int CENT_W     = 8;
    localparam int YOC_W      = 7;
    localparam int SUM_W      = 10;
    localparam int Q7_W       = 7;
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          SHIFT_100 = 19;
    localparam logic [11:0] RECIP_7   = 12'd2341;
    localparam int          SHIFT_7   = 14;

    // Input command codes
    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_ADVANCE = 1'b1
    } cdc_command_t;

    // Operand select for the shared year splitter
    typedef enum logic [1:0] {
        SEL_VALID  = 2'd0,   // year under test: load year or held year
        SEL_LEAP   = 2'd1,   // held year after the update
        SEL_ZELLER = 2'd2    // held year, less one for January/February
    } cdc_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     capture;
        logic     mul;
        logic     div;
        cdc_sel_t sel;
        logic     update;
        logic     latch_leap;
        logic     zsum;
        logic     zmod;
        logic     result;
    } cdc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;   // result register holds an untaken transfer
    } cdc_stat_t;

    // Leap year from century and year-of-century
    function automatic logic leap_of(input logic [CENT_W-1:0] cent,
                                     input logic [YOC_W-1:0] yoc);
        logic r;
        if (yoc != '0)
            r = (yoc[1:0] == 2'd0);
        else
            r = (cent[1:0] == 2'd0);
        return r;
    endfunction

    // Days in month; zero for a month outside 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // Days before the month in a common year
    function automatic logic [ORD_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [ORD_W-1:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // Zeller month term ((mm + 1) * 26) / 10 for mm in 3..14
    function automatic logic [5:0] zeller_term(input logic [MONTH_W-1:0] mm);
        logic [5:0] t;
        case (mm)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

### src/cdc_ctrl.sv
// Sequencer for the calendar date counter: walks one transfer through
// check/update, leap and weekday steps. Depends on cdc_pkg.
module cdc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cdc_pkg::cdc_stat_t stat,
    output cdc_pkg::cdc_cmd_t  cmd
);
    import cdc_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_VMUL     = 11'b000_0000_0010,
        ST_VDIV     = 11'b000_0000_0100,
        ST_UPDATE   = 11'b000_0000_1000,
        ST_LMUL     = 11'b000_0001_0000,
        ST_LDIV     = 11'b000_0010_0000,
        ST_ZMUL     = 11'b000_0100_0000,
        ST_ZDIV     = 11'b000_1000_0000,
        ST_ZSUM     = 11'b001_0000_0000,
        ST_ZMOD     = 11'b010_0000_0000,
        ST_RESULT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SEL_VALID;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_VMUL;
                end
            end
            ST_VMUL:
            begin
                cmd.mul    = 1'b1;
                cmd.sel    = SEL_VALID;
                state_next = ST_VDIV;
            end
            ST_VDIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_LMUL;
            end
            ST_LMUL:
            begin
                cmd.mul    = 1'b1;
                cmd.sel    = SEL_LEAP;
                state_next = ST_LDIV;
            end
            ST_LDIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_ZMUL;
            end
            ST_ZMUL:
            begin
                cmd.latch_leap = 1'b1;
                cmd.mul        = 1'b1;
                cmd.sel        = SEL_ZELLER;
                state_next     = ST_ZDIV;
            end
            ST_ZDIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_ZSUM;
            end
            ST_ZSUM:
            begin
                cmd.zsum   = 1'b1;
                state_next = ST_ZMOD;
            end
            ST_ZMOD:
            begin
                cmd.zmod   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/cdc_dp.sv
// Datapath for the calendar date counter: held date, shared year splitter
// (divide by 100 through a reciprocal), Zeller sum and result register.
// Depends on cdc_pkg.
module cdc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cdc_pkg::cdc_cmd_t                cmd,
    output cdc_pkg::cdc_stat_t               stat,
    input  logic                             in_command,
    input  logic [cdc_pkg::DAY_W-1:0]        in_day,
    input  logic [cdc_pkg::MONTH_W-1:0]      in_month,
    input  logic [cdc_pkg::YEAR_W-1:0]       in_year,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cdc_pkg::OUT_DATA_W-1:0]   out_data
);
    import cdc_pkg::*;

    // Captured transfer
    cdc_command_t       command_reg;
    logic [DAY_W-1:0]   ld_day_reg;
    logic [MONTH_W-1:0] ld_month_reg;
    logic [YEAR_W-1:0]  ld_year_reg;

    // Held date
    logic [DAY_W-1:0]   cur_day_reg, cur_day_next;
    logic [MONTH_W-1:0] cur_month_reg, cur_month_next;
    logic [YEAR_W-1:0]  cur_year_reg, cur_year_next;
    logic               rej_reg, rej_next;

    // Splitter
    logic [YEAR_W-1:0]  split_op;
    logic [YEAR_W-1:0]  op_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [CENT_W-1:0]  cent_div;
    logic [YEAR_W-1:0]  yoc_wide;
    logic [CENT_W-1:0]  cent_reg;
    logic [YOC_W-1:0]   yoc_reg;
    logic               leap_split;
    logic               leap_cur_reg;

    // Weekday
    logic [MONTH_W-1:0] zmm;
    logic [SUM_W-1:0]   zsum;
    logic [SUM_W-1:0]   sum_reg;
    logic [21:0]        q7_prod;
    logic [Q7_W-1:0]    q7_reg;
    logic [2:0]         h7;
    logic [WDAY_W-1:0]  wday;

    // Result fields
    logic [DAY_W-1:0]   last_day;
    logic [ORD_W-1:0]   ordinal;
    logic               month_end;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Capture the accepted transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg  <= cdc_command_t'(in_command);
            ld_day_reg   <= in_day;
            ld_month_reg <= in_month;
            ld_year_reg  <= in_year;
        end
    end

    // Splitter operand
    always_comb
    begin
        case (cmd.sel)
            SEL_VALID:  split_op = (command_reg == CMD_LOAD) ? ld_year_reg : cur_year_reg;
            SEL_ZELLER: split_op = (cur_month_reg <= MONTH_FEB) ? cur_year_reg - YEAR_MIN
                                                                : cur_year_reg;
            default:    split_op = cur_year_reg;
        endcase
    end

    assign cent_div   = prod_reg[SHIFT_100 +: CENT_W];
    assign yoc_wide   = op_reg - YEAR_W'(cent_div) * 14'd100;
    assign leap_split = leap_of(cent_reg, yoc_reg);

    // Splitter: multiply by reciprocal, then shift and remainder
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            op_reg   <= split_op;
            prod_reg <= PROD_W'(split_op) * PROD_W'(RECIP_100);
        end
        if (cmd.div)
        begin
            cent_reg <= cent_div;
            yoc_reg  <= yoc_wide[YOC_W-1:0];
        end
        if (cmd.latch_leap)
            leap_cur_reg <= leap_split;
    end

    // Load check or one-day advance
    always_comb
    begin
        cur_day_next   = cur_day_reg;
        cur_month_next = cur_month_reg;
        cur_year_next  = cur_year_reg;
        rej_next       = 1'b0;
        last_day       = '0;
        if (command_reg == CMD_LOAD)
        begin
            last_day = month_days(ld_month_reg, leap_split);
            if (ld_year_reg >= YEAR_MIN && ld_year_reg <= YEAR_MAX &&
                ld_day_reg != '0 && ld_day_reg <= last_day)
            begin
                cur_day_next   = ld_day_reg;
                cur_month_next = ld_month_reg;
                cur_year_next  = ld_year_reg;
            end
            else
                rej_next = 1'b1;
        end
        else
        begin
            last_day = month_days(cur_month_reg, leap_split);
            if (cur_day_reg < last_day)
                cur_day_next = cur_day_reg + DAY_W'(1);
            else if (cur_month_reg < MONTH_DEC)
            begin
                cur_day_next   = RST_DAY;
                cur_month_next = cur_month_reg + MONTH_W'(1);
            end
            else if (cur_year_reg < YEAR_MAX)
            begin
                cur_day_next   = RST_DAY;
                cur_month_next = RST_MONTH;
                cur_year_next  = cur_year_reg + YEAR_W'(1);
            end
            else
                rej_next = 1'b1;
        end
    end

    // Held date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_day_reg   <= RST_DAY;
            cur_month_reg <= RST_MONTH;
            cur_year_reg  <= RST_YEAR;
        end
        else if (cmd.update)
        begin
            cur_day_reg   <= cur_day_next;
            cur_month_reg <= cur_month_next;
            cur_year_reg  <= cur_year_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
            rej_reg <= rej_next;
    end

    // Zeller sum, then divide by 7 through a reciprocal
    assign zmm  = (cur_month_reg <= MONTH_FEB) ? cur_month_reg + MONTH_DEC : cur_month_reg;
    assign zsum = SUM_W'(cur_day_reg) + SUM_W'(zeller_term(zmm)) + SUM_W'(yoc_reg)
                + SUM_W'(yoc_reg[YOC_W-1:2]) + SUM_W'(cent_reg[CENT_W-1:2])
                + SUM_W'(cent_reg) * SUM_W'(5);
    assign q7_prod = 22'(sum_reg) * 22'(RECIP_7);

    always_ff @(posedge clk)
    begin
        if (cmd.zsum)
            sum_reg <= zsum;
        if (cmd.zmod)
            q7_reg <= q7_prod[SHIFT_7 +: Q7_W];
    end

    // Remainder, remapped so that 0 is Monday
    always_comb
    begin
        logic [SUM_W-1:0] rem;
        rem  = sum_reg - SUM_W'(q7_reg) * SUM_W'(7);
        h7   = rem[2:0];
        wday = (h7 >= 3'd2) ? h7 - 3'd2 : h7 + 3'd5;
    end

    assign ordinal   = days_before(cur_month_reg) + ORD_W'(cur_day_reg)
                     + ORD_W'(leap_cur_reg && cur_month_reg > MONTH_FEB);
    assign month_end = (cur_day_reg == month_days(cur_month_reg, leap_cur_reg));

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
            out_data_reg <= {2'b00, rej_reg, month_end, leap_cur_reg, ordinal, wday,
                             cur_year_reg, cur_month_reg, cur_day_reg};
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;

endmodule

### src/calendar_date_counter_top.sv
// Top level of the calendar date counter: joins the sequencer and datapath.
// Depends on cdc_pkg, cdc_ctrl and cdc_dp.
//
// Usage:
//   Slave side (s_axis): one transfer is one command. tuser holds the
//   command (0 = load date, 1 = advance one day); tdata holds the load
//   date. A load is checked (year 1..9999, month 1..12, day within the
//   month) and refused if invalid; an advance past 31 Dec 9999 is refused.
//   Master side (m_axis): one transfer per command with the held date,
//   weekday (0 = Monday), day of year, leap, month-end and refused flags.
//   The sequencer handles one command at a time and takes no new command
//   until the last has been through all its steps; it uses a single
//   divide-by-100 splitter three times (check year, leap year, weekday
//   year), with a multiply step and a divide step each.
//   s_axis_tready is high only while the sequencer is idle; a new command
//   may enter while the previous result still waits in the output register.
//   If the receiver stalls, the next result waits in its last step.
//   Reset: date becomes Saturday 1 January 2000, no result pending.
module calendar_date_counter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // load_day[4:0], load_month[8:5], load_year[22:9]
    input  logic [0:0]  s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // day_out[4:0], month_out[8:5], year_out[22:9],
                                        // weekday[25:23], ordinal_day[34:26],
                                        // leap_flag[35], month_end_flag[36], rejected[37]
);
    import cdc_pkg::*;

    cdc_cmd_t  cmd;
    cdc_stat_t stat;

    cdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_command (s_axis_tuser[0]),
        .in_day     (s_axis_tdata[4:0]),
        .in_month   (s_axis_tdata[8:5]),
        .in_year    (s_axis_tdata[22:9]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

    // A result is never produced right after a command enters
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result appeared one cycle after input transfer");

    // The result register is never overwritten while a transfer is pending
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

    // Held date is always a valid month and nonzero day
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8:5] != 4'd0 && m_axis_tdata[8:5] <= 4'd12 &&
                           m_axis_tdata[4:0] != 5'd0))
        else $error("output date out of range");

    // Weekday stays within 0..6
    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[25:23] != 3'd7))
        else $error("weekday out of range");

endmodule
